/* rtl/core/ecarow_pkg.sv */
// Shared types, constants and the rule bank for the elementary CA row generator.
// No dependencies; every other file in rtl/core imports this package.
package ecarow_pkg;

   localparam int ROW_BITS      = 64;   // fixed width of the row field on the ports
   localparam int ROW_WIDTH_DEF = 64;   // default ring length
   localparam int BANK_SIZE     = 9;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEFAULT_RULE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_RULE_TIME = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_RULE_TIME   = 2'd2;

   localparam logic [7:0]  DEFAULT_RULE_RST    = 8'd30;
   localparam logic [15:0] FIRST_RULE_TIME_RST = 16'd100;
   localparam logic [14:0] MIN_RULE_TIME_RST   = 15'd50;

   localparam logic MODE_RESTART = 1'b0;
   localparam logic MODE_STEP    = 1'b1;

   localparam logic [7:0] RULE_BANK [BANK_SIZE] = '{
      8'd30, 8'd57, 8'd18, 8'd90, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133
   };

   typedef struct packed {
      logic                mode;
      logic                seed_single;
      logic [ROW_BITS-1:0] seed_row;
      logic [3:0]          reset_rule_pick;
      logic [3:0]          timed_rule_pick;
      logic [14:0]         rule_time_offset;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [7:0]          current_rule;
      logic                was_reseeded;
      logic                rule_timed_out;
   } rsp_type;

   // what a cell shows its two neighbors
   typedef struct packed {
      logic cur;    // stored bit
      logic mid;    // first new bit ORed with the seed bit
   } cell_link_type;

   // controller to every cell
   typedef struct packed {
      logic       advance;
      logic       load;
      logic       reseed;
      logic [7:0] step_rule;
      logic [7:0] reseed_rule;
   } cell_ctrl_type;

   // picks above the last bank entry saturate to it
   function automatic logic [7:0] bank_rule(input logic [3:0] pick);
      logic [3:0] idx;
      idx = (pick > 4'(BANK_SIZE - 1)) ? 4'(BANK_SIZE - 1) : pick;
      return RULE_BANK[idx];
   endfunction

endpackage

/* rtl/core/ecarow_cell.sv */
// One ring cell: holds its bit, loads its seed bit on a restart, else works out one or two generations.
// Depends on ecarow_pkg.
module ecarow_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  ecarow_pkg::cell_ctrl_type ctrl,
   input  logic                      seed_bit,
   input  ecarow_pkg::cell_link_type left_link,
   input  ecarow_pkg::cell_link_type right_link,
   output ecarow_pkg::cell_link_type link_out,
   output logic                      first_bit,
   output logic                      next_bit
);
   import ecarow_pkg::*;

   logic bit_ff;
   logic bit_in;
   logic second_bit;
   logic self_mid;

   // rule bit index is left + 2*self + 4*right
   assign first_bit  = ctrl.step_rule[{right_link.cur, bit_ff, left_link.cur}];
   assign self_mid   = first_bit | seed_bit;
   assign second_bit = ctrl.reseed_rule[{right_link.mid, self_mid, left_link.mid}];

   assign link_out.cur = bit_ff;
   assign link_out.mid = self_mid;

   always_comb begin
      if (ctrl.load) begin
         bit_in = seed_bit;
      end else if (ctrl.reseed) begin
         bit_in = second_bit;
      end else begin
         bit_in = first_bit;
      end
   end

   assign next_bit = bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else if (ctrl.advance) begin
         bit_ff <= bit_in;
      end
   end

endmodule

/* rtl/core/ecarow_ctrl.sv */
// Rule and rule-time control: config registers, active rule, row counters.
// Depends on ecarow_pkg.
module ecarow_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [ecarow_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ecarow_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                  accept,
   input  ecarow_pkg::req_type                   req,
   input  logic                                  dead_or_full,
   output ecarow_pkg::cell_ctrl_type             cell_ctrl,
   output logic [7:0]                            rule_next,
   output logic                                  reseeded,
   output logic                                  timed_out
);
   import ecarow_pkg::*;

   logic [7:0]  default_rule_ff;
   logic [15:0] first_rule_time_ff;
   logic [14:0] min_rule_time_ff;

   logic [7:0]  rule_ff;
   logic [15:0] since_ff;
   logic [15:0] until_ff;

   logic [7:0]  rule_in;
   logic [15:0] since_in;
   logic [15:0] until_in;

   logic        step;
   logic [16:0] since_sum;
   logic [15:0] since_sat;
   logic [7:0]  reseed_rule;

   assign step        = (req.mode == MODE_STEP);
   assign reseeded    = step & dead_or_full;
   assign reseed_rule = bank_rule(req.reset_rule_pick);

   // one row made normally, two on a reseed; counter sticks at all ones
   assign since_sum = {1'b0, since_ff} + (reseeded ? 17'd2 : 17'd1);
   assign since_sat = since_sum[16] ? 16'hFFFF : since_sum[15:0];
   assign timed_out = step & (since_sat >= until_ff);

   always_comb begin
      rule_in  = rule_ff;
      since_in = since_sat;
      until_in = until_ff;
      if (!step) begin
         rule_in  = default_rule_ff;
         since_in = '0;
         until_in = first_rule_time_ff;
      end else if (timed_out) begin
         rule_in  = bank_rule(req.timed_rule_pick);
         since_in = '0;
         until_in = {1'b0, min_rule_time_ff} + {1'b0, req.rule_time_offset};
      end else if (reseeded) begin
         rule_in  = reseed_rule;
      end
   end

   assign rule_next = rule_in;

   assign cell_ctrl.advance     = accept;
   assign cell_ctrl.load        = !step;
   assign cell_ctrl.reseed      = reseeded;
   assign cell_ctrl.step_rule   = rule_ff;
   assign cell_ctrl.reseed_rule = reseed_rule;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_rule_ff    <= DEFAULT_RULE_RST;
         first_rule_time_ff <= FIRST_RULE_TIME_RST;
         min_rule_time_ff   <= MIN_RULE_TIME_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEFAULT_RULE:    default_rule_ff    <= csr_data[7:0];
            CSR_FIRST_RULE_TIME: first_rule_time_ff <= csr_data;
            CSR_MIN_RULE_TIME:   min_rule_time_ff   <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff  <= DEFAULT_RULE_RST;
         since_ff <= '0;
         until_ff <= FIRST_RULE_TIME_RST;
      end else if (accept) begin
         rule_ff  <= rule_in;
         since_ff <= since_in;
         until_ff <= until_in;
      end
   end

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && !step |=> since_ff == '0 && rule_ff == $past(default_rule_ff))
      else $error("restart transaction did not clear the row counter");

   a_timed_clears: assert property (@(posedge clock) disable iff (reset)
      accept && timed_out |=> since_ff == '0)
      else $error("timed rule change did not clear the row counter");

   a_counter_bounded: assert property (@(posedge clock) disable iff (reset)
      accept && step && !timed_out |=> since_ff < until_ff)
      else $error("row counter passed rule time without a rule change");

endmodule

/* rtl/core/ecarow_obuf.sv */
// Two-entry output buffer (output register plus skid) for result transactions.
// Depends on ecarow_pkg.
module ecarow_obuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  ecarow_pkg::rsp_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output ecarow_pkg::rsp_type out_data
);
   import ecarow_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    take;
   logic    put;

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign take      = out_valid_ff & ~out_stall;
   assign put       = in_valid & ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (put) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (put) begin
         if (!out_valid_ff || take) begin
            out_data_ff <= in_data;
         end else begin
            skid_data_ff <= in_data;
         end
      end
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && take |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on drain");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stall |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result changed");

endmodule

/* rtl/core/elementary_ca_row_generator_core.sv */
// Top level of the elementary cellular automaton row generator: ring of cells,
// rule control and output buffer. Depends on ecarow_pkg, ecarow_cell, ecarow_ctrl, ecarow_obuf.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_stall  ecarow_pkg::req_type
//   rsp_*        out         rsp_valid/rsp_stall  ecarow_pkg::rsp_type
//   csr_*        in          csr_write_en         csr_index, csr_data
//
// One transaction per cycle while req_stall is low; each result is registered in the output buffer.
// The loop through the cell ring (one or two generations) and the dead/full
// detect sets the clock path; every row is finished in the accepting cycle.
// Synchronous reset clears the row, counters and buffer, and loads config defaults.
// req_stall rises only when the output register and the skid entry are both full.
module elementary_ca_row_generator_core #(
   parameter int WIDTH = ecarow_pkg::ROW_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ecarow_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ecarow_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_write_en,
   input  logic [ecarow_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ecarow_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ecarow_pkg::*;

   logic           accept;
   logic [WIDTH-1:0] seed_vec;
   logic [WIDTH-1:0] first_row;
   logic [WIDTH-1:0] next_row;
   logic           dead_or_full;
   cell_ctrl_type  cell_ctrl;
   cell_link_type  links [WIDTH];
   logic [7:0]     rule_next;
   logic           reseeded;
   logic           timed_out;
   rsp_type        rsp_in;

   assign accept = req_valid & ~req_stall;

   always_comb begin
      if (req_data.seed_single) begin
         seed_vec = '0;
         seed_vec[WIDTH/2] = 1'b1;
      end else begin
         seed_vec = req_data.seed_row[WIDTH-1:0];
      end
   end

   assign dead_or_full = ~|first_row | &first_row;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? WIDTH - 1 : i - 1;
      localparam int RIGHT = (i == WIDTH - 1) ? 0 : i + 1;
      ecarow_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .seed_bit   (seed_vec[i]),
         .left_link  (links[LEFT]),
         .right_link (links[RIGHT]),
         .link_out   (links[i]),
         .first_bit  (first_row[i]),
         .next_bit   (next_row[i])
      );
   end

   ecarow_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .req          (req_data),
      .dead_or_full (dead_or_full),
      .cell_ctrl    (cell_ctrl),
      .rule_next    (rule_next),
      .reseeded     (reseeded),
      .timed_out    (timed_out)
   );

   assign rsp_in.row            = ROW_BITS'(next_row);
   assign rsp_in.current_rule   = rule_next;
   assign rsp_in.was_reseeded   = reseeded;
   assign rsp_in.rule_timed_out = timed_out;

   ecarow_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (rsp_in),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction left no result");

   a_restart_flags: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == MODE_RESTART |-> !rsp_in.was_reseeded
         && !rsp_in.rule_timed_out)
      else $error("restart transaction raised a status flag");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule
